@@ sv/min_max_bucket_decimator_defines.svh @@
// Assertion macros used by the checker of the decimator.
`ifndef MIN_MAX_BUCKET_DECIMATOR_DEFINES_SVH
`define MIN_MAX_BUCKET_DECIMATOR_DEFINES_SVH

// ante holds at one edge, cons must hold at the next (outside reset)
`define MMBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: sequence check failed");

// cons must hold at the edge after a reset edge
`define MMBD_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("%m: post-reset check failed");

`endif

@@ sv/mmbd_pkg.sv @@
package mmbd_pkg;

  localparam int TIME_BITS  = 32;
  localparam int VALUE_BITS = 32;
  localparam int CFG_BITS   = 32;
  localparam int BKT_BITS   = 16;
  localparam int SCALE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int IN_DATA_W  = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATE_EN  = 3'd5;

  // results one item can cause, and depth of the result queue
  localparam int RES_MAX    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                         req_type;
    logic [TIME_BITS-1:0]         sample_time;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         value_valid;
  } in_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  range_start;
    logic [TIME_BITS-1:0]  range_end;
    logic [BKT_BITS-1:0]   bucket_count;
    logic [SCALE_BITS-1:0] bucket_scale;
    logic [TIME_BITS-1:0]  gap_threshold;
    logic                  decimate_enable;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]         point_time;
    logic signed [VALUE_BITS-1:0] point_value;
    logic                         segment_start;
    logic                         last_of_run;
  } point_t;

  typedef struct packed {
    logic   vld;
    point_t pt;
  } res_t;

  typedef res_t [RES_MAX-1:0] res_vec_t;

endpackage

@@ sv/mmbd_core.sv @@
module mmbd_core
  import mmbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  input  cfg_t     cfg,
  output res_vec_t res
);

  logic                         bucket_open_r, bucket_open_nxt;
  logic                         seg_open_r, seg_open_nxt;
  logic                         seg_emitted_r, seg_emitted_nxt;
  logic [BKT_BITS-1:0]          active_r;
  logic [TIME_BITS-1:0]         min_t_r, max_t_r, last_t_r;
  logic signed [VALUE_BITS-1:0] min_v_r, max_v_r;

  logic [TIME_BITS-1:0]              lo, hi, t, offset;
  logic signed [VALUE_BITS-1:0]      v;
  logic [TIME_BITS+SCALE_BITS-1:0]   prod;
  logic [TIME_BITS+FRAC_BITS-1:0]    q;
  logic [BKT_BITS-1:0]               top, bkt;
  logic is_end, in_rng, smp_ok, smp_bad, gap_hit, close, dec;
  logic new_bkt, do_flush, ord, same, two, pass, emit_mid;

  always_comb begin
    t      = item.sample_time;
    v      = item.sample_value;
    dec    = cfg.decimate_enable;
    lo     = (cfg.range_start > cfg.range_end) ? cfg.range_end : cfg.range_start;
    hi     = (cfg.range_start > cfg.range_end) ? cfg.range_start : cfg.range_end;
    is_end = item.req_type;
    in_rng = (t >= lo) && (t <= hi);
    smp_ok  = !is_end && in_rng && item.value_valid;
    smp_bad = !is_end && in_rng && !item.value_valid;
    gap_hit = seg_open_r && (cfg.gap_threshold != '0) && (t > last_t_r)
              && ((t - last_t_r) > cfg.gap_threshold);
    close   = is_end || (smp_bad && seg_open_r) || (smp_ok && gap_hit);

    offset = t - lo;
    prod   = TIME_BITS'(offset) * cfg.bucket_scale;
    q      = prod[TIME_BITS+SCALE_BITS-1:FRAC_BITS];
    top    = (cfg.bucket_count == '0) ? '0 : cfg.bucket_count - BKT_BITS'(1);
    bkt    = (q > (TIME_BITS+FRAC_BITS)'(top)) ? top : q[BKT_BITS-1:0];

    new_bkt  = smp_ok && dec && (!bucket_open_r || close || (bkt != active_r));
    do_flush = bucket_open_r && (close || (smp_ok && dec && (bkt != active_r)));
    ord      = min_t_r <= max_t_r;
    same     = (min_t_r == max_t_r) && (min_v_r == max_v_r);
    two      = do_flush && (!ord || !same);
    pass     = smp_ok && !dec;
    emit_mid = close ? 1'b0 : (do_flush ? 1'b1 : seg_emitted_r);

    res[0].vld              = do_flush;
    res[0].pt.point_time    = ord ? min_t_r : max_t_r;
    res[0].pt.point_value   = ord ? min_v_r : max_v_r;
    res[0].pt.segment_start = !seg_emitted_r;
    res[0].pt.last_of_run   = !two && !pass;

    res[1].vld              = two;
    res[1].pt.point_time    = ord ? max_t_r : min_t_r;
    res[1].pt.point_value   = ord ? max_v_r : min_v_r;
    res[1].pt.segment_start = 1'b0;
    res[1].pt.last_of_run   = !pass;

    res[2].vld              = pass;
    res[2].pt.point_time    = t;
    res[2].pt.point_value   = v;
    res[2].pt.segment_start = !emit_mid;
    res[2].pt.last_of_run   = 1'b1;

    bucket_open_nxt = smp_ok ? dec : (close ? 1'b0 : bucket_open_r);
    seg_open_nxt    = smp_ok ? 1'b1 : (close ? 1'b0 : seg_open_r);
    seg_emitted_nxt = pass ? 1'b1 : emit_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_open_r <= 1'b0;
      seg_open_r    <= 1'b0;
      seg_emitted_r <= 1'b0;
    end else if (fire) begin
      bucket_open_r <= bucket_open_nxt;
      seg_open_r    <= seg_open_nxt;
      seg_emitted_r <= seg_emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (smp_ok) begin
        last_t_r <= t;
      end
      if (new_bkt) begin
        active_r <= bkt;
        min_t_r  <= t;
        max_t_r  <= t;
        min_v_r  <= v;
        max_v_r  <= v;
      end else if (smp_ok && dec) begin
        if (v < min_v_r) begin
          min_t_r <= t;
          min_v_r <= v;
        end
        if (v > max_v_r) begin
          max_t_r <= t;
          max_v_r <= v;
        end
      end
    end
  end

endmodule

@@ sv/mmbd_out_fifo.sv @@
module mmbd_out_fifo
  import mmbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  res_vec_t res,
  output logic     room,
  output logic     pop_vld,
  input  logic     pop_rdy,
  output point_t   head
);

  point_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0]   wa [RES_MAX];
  logic [FIFO_CW-1:0]   n_push;
  logic                 pop;

  always_comb begin
    wa[0] = wp_r;
    for (int k = 1; k < RES_MAX; k++) begin
      wa[k] = wa[k-1] + FIFO_AW'(res[k-1].vld);
    end
    n_push = '0;
    if (push) begin
      for (int k = 0; k < RES_MAX; k++) begin
        n_push = n_push + FIFO_CW'(res[k].vld);
      end
    end
    pop     = pop_vld && pop_rdy;
    wp_nxt  = wp_r + n_push[FIFO_AW-1:0];
    rp_nxt  = rp_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + n_push - FIFO_CW'(pop);
    room    = cnt_r <= FIFO_CW'(FIFO_DEPTH - RES_MAX);
    pop_vld = cnt_r != '0;
    head    = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (push && res[k].vld) begin
        mem_r[wa[k]] <= res[k].pt;
      end
    end
  end

endmodule

@@ sv/min_max_bucket_decimator.sv @@
// channel  dir  tdata (low bit up)             tuser (low bit up)          tlast
// in_      in   sample_time, sample_value      req_type, value_valid       -
// out_     out  point_time, point_value        segment_start               last_of_run
// cfg_     in   plain write: cfg_we, cfg_idx, cfg_wdata (no read-back)
//
// One item per cycle while out_tready is high and items cause at most one result;
// results leave at one per cycle, so items causing two or three results pace the input.
// Latency: input register, then one compute stage into a 4-entry result queue.
// An item enters compute only when the queue has room for three results.
// rst_n (synchronous) clears control state and loads register defaults.
module min_max_bucket_decimator
  import mmbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_time, sample_value
  input  logic [1:0]            in_tuser,   // req_type, value_valid
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // point_time, point_value
  output logic                  out_tuser,  // segment_start
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_BITS-1:0]   cfg_wdata
);

  cfg_t     cfg_r;
  in_item_t item_r;
  logic     item_vld_r;
  logic     in_fire, core_fire, room;
  res_vec_t res;
  point_t   head;

  assign core_fire = item_vld_r && room;
  assign in_tready = !item_vld_r || core_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_fire) begin
      item_vld_r <= 1'b1;
    end else if (core_fire) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type     <= in_tuser[0];
      item_r.value_valid  <= in_tuser[1];
      item_r.sample_time  <= in_tdata[TIME_BITS-1:0];
      item_r.sample_value <= in_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_start     <= '0;
      cfg_r.range_end       <= '1;
      cfg_r.bucket_count    <= BKT_BITS'(1024);
      cfg_r.bucket_scale    <= '0;
      cfg_r.gap_threshold   <= '0;
      cfg_r.decimate_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RANGE_START:  cfg_r.range_start     <= cfg_wdata[TIME_BITS-1:0];
        CFG_RANGE_END:    cfg_r.range_end       <= cfg_wdata[TIME_BITS-1:0];
        CFG_BUCKET_COUNT: cfg_r.bucket_count    <= cfg_wdata[BKT_BITS-1:0];
        CFG_BUCKET_SCALE: cfg_r.bucket_scale    <= cfg_wdata[SCALE_BITS-1:0];
        CFG_GAP_THRESH:   cfg_r.gap_threshold   <= cfg_wdata[TIME_BITS-1:0];
        CFG_DECIMATE_EN:  cfg_r.decimate_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mmbd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (core_fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  mmbd_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (core_fire),
    .res     (res),
    .room    (room),
    .pop_vld (out_tvalid),
    .pop_rdy (out_tready),
    .head    (head)
  );

  assign out_tdata = OUT_DATA_W'({head.point_value, head.point_time});
  assign out_tuser = head.segment_start;
  assign out_tlast = head.last_of_run;

endmodule

@@ sv/mmbd_checker.sv @@
`include "min_max_bucket_decimator_defines.svh"

module mmbd_checker
  import mmbd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  `MMBD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `MMBD_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable({out_tdata, out_tuser, out_tlast}))
  `MMBD_ASSERT_AFTER_RESET(a_rst_out_empty, !out_tvalid)
  `MMBD_ASSERT_AFTER_RESET(a_rst_in_ready, in_tready)

endmodule

bind min_max_bucket_decimator mmbd_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
